// ===== rtl/csg_pkg.sv =====
// Shared types and constants for the gray-level contrast stretch unit.
package csg_pkg;

  localparam int PIXELS_PER_WORD_DEF = 4;
  localparam int WORD_FIELDS         = 4;
  localparam int PIX_W               = 8;
  localparam int NUM_W               = 17;  // 2*255*255 + 255 fits in 17 bits
  localparam int DIV_W               = 9;   // twice the span, up to 510
  localparam int QBITS               = 8;   // quotient never exceeds 255
  localparam int SHIFT_W             = DIV_W + QBITS - 1;

  localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [PIX_W-1:0] FLAT_VALUE = 8'd128;
  localparam logic [PIX_W-1:0] ZERO_VALUE = 8'd0;

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_MAP     = 1'b1;

  typedef logic [WORD_FIELDS-1:0][PIX_W-1:0] pix_word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic measure;  // take a measure item into low/high tracking
    logic load;     // set up the divider lanes for a map item
    logic step;     // one quotient bit on every lane that is not bypassed
    logic capture;  // move lane results into the output register
  } csg_cmd_t;

endpackage

// ===== rtl/csg_ctrl.sv =====
// Controller: item handshake, divider step count and output register valid.
module csg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              req_type,
  output logic              out_tvalid,
  input  logic              out_tready,
  output csg_pkg::csg_cmd_t cmd
);
  import csg_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;
  localparam int         CNT_W  = $clog2(QBITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QBITS - 1);

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_acc;
  logic             out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  // Sequence one item: measure on acceptance, map through the divider
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (req_type == REQ_MAP) begin
            cmd.load  = 1'b1;
            state_nxt = S_DIV;
            cnt_nxt   = '0;
          end else begin
            cmd.measure = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_HOLD;
          cnt_nxt   = '0;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // Hold controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A map item always enters the divider
  a_map_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && req_type == REQ_MAP) |=> (state_r == S_DIV && cnt_r == '0))
    else $error("map item did not start the divider");

  // The step count runs only inside the divider phase
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DIV) |-> (cnt_r == '0))
    else $error("step count left nonzero outside divider phase");

  // The last quotient step always hands over to the hold state
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == CNT_LAST) |=> (state_r == S_HOLD))
    else $error("divider phase did not end after last step");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (!out_valid_r || out_tready))
    else $error("output register overwritten while full");

endmodule

// ===== rtl/csg_dpath.sv =====
// Datapath: low/high tracking, per-pixel restoring divider lanes, output register.
module csg_dpath #(
  parameter int PIXELS_PER_WORD = csg_pkg::PIXELS_PER_WORD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  csg_pkg::csg_cmd_t  cmd,
  input  logic               frame_start,
  input  csg_pkg::pix_word_t pix_in,
  output csg_pkg::pix_word_t pix_out,
  output logic               flat_frame
);
  import csg_pkg::*;

  logic [PIX_W-1:0]   low_r, low_nxt;
  logic [PIX_W-1:0]   high_r, high_nxt;
  logic [SHIFT_W-1:0] dsh_r;
  logic               flat_r;
  logic [WORD_FIELDS-1:0][NUM_W-1:0] rem_r;
  logic [WORD_FIELDS-1:0][QBITS-1:0] q_r;
  logic [WORD_FIELDS-1:0]            byp_r;
  pix_word_t          res_r;
  logic               res_flat_r;
  logic [PIX_W-1:0]   span;
  logic               is_flat;

  assign span    = high_r - low_r;
  assign is_flat = (low_r == high_r);

  // Fold the word's active pixels into the running low and high, restarting them on frame_start
  always_comb begin
    low_nxt  = frame_start ? FULL_SCALE : low_r;
    high_nxt = frame_start ? ZERO_VALUE : high_r;
    for (int i = 0; i < WORD_FIELDS; i++) begin
      if (i < PIXELS_PER_WORD) begin
        if (pix_in[i] < low_nxt)  low_nxt  = pix_in[i];
        if (pix_in[i] > high_nxt) high_nxt = pix_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= FULL_SCALE;
      high_r <= ZERO_VALUE;
    end else if (cmd.measure) begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  // Divider lanes: load numerator or fixed value, then one quotient bit per step
  // Numerator is 510*(p-low) + span, built as 512*d - 2*d + span
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dsh_r  <= {span, 1'b0, {(QBITS-1){1'b0}}};
      flat_r <= is_flat;
      for (int i = 0; i < WORD_FIELDS; i++) begin
        rem_r[i] <= ({pix_in[i] - low_r, 9'd0})
                  - ({8'd0, pix_in[i] - low_r, 1'b0})
                  + {{(NUM_W-PIX_W){1'b0}}, span};
        byp_r[i] <= 1'b1;
        if (i >= PIXELS_PER_WORD) begin
          q_r[i] <= ZERO_VALUE;
        end else if (is_flat) begin
          q_r[i] <= FLAT_VALUE;
        end else if (pix_in[i] < low_r) begin
          q_r[i] <= ZERO_VALUE;
        end else if (pix_in[i] > high_r) begin
          q_r[i] <= FULL_SCALE;
        end else begin
          q_r[i]   <= '0;
          byp_r[i] <= 1'b0;
        end
      end
    end else if (cmd.step) begin
      dsh_r <= dsh_r >> 1;
      for (int i = 0; i < WORD_FIELDS; i++) begin
        if (!byp_r[i]) begin
          if (rem_r[i] >= {1'b0, dsh_r}) begin
            rem_r[i] <= rem_r[i] - {1'b0, dsh_r};
            q_r[i]   <= {q_r[i][QBITS-2:0], 1'b1};
          end else begin
            q_r[i]   <= {q_r[i][QBITS-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < WORD_FIELDS; i++) begin
        res_r[i] <= q_r[i];
      end
      res_flat_r <= flat_r;
    end
  end

  assign pix_out    = res_r;
  assign flat_frame = res_flat_r;

endmodule

// ===== rtl/contrast_stretch_gray_unit.sv =====
// Top level of the min-max contrast stretch unit for 8-bit gray pixel words.
//
//  channel | direction | tdata                          | tuser
//  in_     | in        | pixel_a..pixel_d (32 bits)     | req_type, frame_start
//  out_    | out       | out_a..out_d (32 bits)         | flat_frame
//
//  A measure item updates the tracked low and high when accepted; a map item goes
//  through accept, 8 quotient steps of the four restoring divider lanes and load of the output register.
//  Reset sets the tracked low to 255 and high to 0 and empties the output.
//  A result waits in the output register while the next item is accepted;
//  a map item that finishes while that register is still full holds its lanes.
module contrast_stretch_gray_unit #(
  parameter int PIXELS_PER_WORD = csg_pkg::PIXELS_PER_WORD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pixel_a[7:0], pixel_b[15:8], pixel_c[23:16], pixel_d[31:24]
  input  logic [1:0]  in_tuser,   // req_type[0], frame_start[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_a[7:0], out_b[15:8], out_c[23:16], out_d[31:24]
  output logic [0:0]  out_tuser   // flat_frame[0]
);
  import csg_pkg::*;

  csg_cmd_t  cmd;
  pix_word_t pix_in;
  pix_word_t pix_out;
  logic      flat_frame;

  // Unpack the input word and pack the output word: first field in the lowest byte
  always_comb begin
    for (int i = 0; i < WORD_FIELDS; i++) begin
      pix_in[i]                  = in_tdata[i*PIX_W +: PIX_W];
      out_tdata[i*PIX_W +: PIX_W] = pix_out[i];
    end
  end

  assign out_tuser[0] = flat_frame;

  csg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .req_type   (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  csg_dpath #(
    .PIXELS_PER_WORD (PIXELS_PER_WORD)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .frame_start (in_tuser[1]),
    .pix_in      (pix_in),
    .pix_out     (pix_out),
    .flat_frame  (flat_frame)
  );

endmodule
